FILE: rtl/tedr_pkg.sv
// ----------------------------------------------------------------------------
// tedr_pkg - shared definitions for the touch event record decoder
// Record layout constants, configuration register codes, result type and
// the coordinate mirror function.
// ----------------------------------------------------------------------------
package tedr_pkg;

	localparam int REC_LEN     = 6;   // bytes per finger record
	localparam int HELD_LEN    = 5;   // bytes held before the closing byte
	localparam int MAX_RECORDS = 10;  // records allowed per packet
	localparam int POS_W       = 3;   // width of the byte position counter
	localparam int CNT_W       = 4;   // width of the record counter
	localparam int COORD_W     = 12;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [COORD_W-1:0] X_LIMIT_RST = 12'd720;
	localparam logic [COORD_W-1:0] Y_LIMIT_RST = 12'd1280;

	// configuration register indices
	localparam logic [1:0] CFG_INV_X   = 2'd0;
	localparam logic [1:0] CFG_INV_Y   = 2'd1;
	localparam logic [1:0] CFG_X_LIMIT = 2'd2;
	localparam logic [1:0] CFG_Y_LIMIT = 2'd3;

	typedef struct packed {
		logic [3:0]         slot_id;
		logic               touching;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [7:0]         touch_major;
		logic [7:0]         pressure;
		logic               packet_end;
		logic               packet_too_long;
	} result_t;

	// mirror against the panel limit, clamped at zero
	function automatic logic [COORD_W-1:0] mirror(
		input logic [COORD_W-1:0] v,
		input logic [COORD_W-1:0] lim,
		input logic               en
	);
		logic [COORD_W-1:0] r;
		if (!en) begin
			r = v;
		end else if (v > lim) begin
			r = '0;
		end else begin
			r = lim - v;
		end
		return r;
	endfunction

endpackage

FILE: rtl/touch_event_record_decoder.sv
// ----------------------------------------------------------------------------
// touch_event_record_decoder - touch event packet to finger record decoder
// Gathers 6-byte finger records from a byte stream and decodes each into
// slot, touching flag, mirrored X/Y, width and pressure.
// ----------------------------------------------------------------------------
// The result of a record is registered on the transfer of its closing byte
// (sixth byte, or the byte flagged packet_last) and is valid in the cycle after.
// Throughput: one byte per cycle; a byte is taken even while a finished result
// waits at the output, unless it would close another record while out_ready is low.
// Reset (arst_n low, asynchronous): position and record count cleared, the
// output register emptied, registers back to no mirroring and 720 x 1280.
// ----------------------------------------------------------------------------
module touch_event_record_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	// packet byte stream
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  packet_byte,
	input  logic        packet_last,
	// decoded records
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  slot_id,
	output logic        touching,
	output logic [11:0] pos_x,
	output logic [11:0] pos_y,
	output logic [7:0]  touch_major,
	output logic [7:0]  pressure,
	output logic        packet_end,
	output logic        packet_too_long
);

	// configuration registers
	logic                             inv_x_q;
	logic                             inv_y_q;
	logic [tedr_pkg::COORD_W-1:0]     x_limit_q;
	logic [tedr_pkg::COORD_W-1:0]     y_limit_q;

	// record assembly state
	logic [tedr_pkg::POS_W-1:0]       byte_pos_q;
	logic [7:0]                       held_q [tedr_pkg::HELD_LEN];
	logic [tedr_pkg::CNT_W-1:0]       rec_cnt_q;

	// output register
	logic                             out_valid_q;
	tedr_pkg::result_t                res_q;

	logic [tedr_pkg::POS_W-1:0]       pos_c;
	logic                             closing_c;
	logic                             in_xfer;
	logic [7:0]                       rec_c [tedr_pkg::REC_LEN];
	logic [tedr_pkg::COORD_W-1:0]     raw_x_c;
	logic [tedr_pkg::COORD_W-1:0]     raw_y_c;
	tedr_pkg::result_t                res_c;

	// Config writes are always taken; the user must send them only while the block idles, which it does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_x_q   <= 1'b0;
			inv_y_q   <= 1'b0;
			x_limit_q <= tedr_pkg::X_LIMIT_RST;
			y_limit_q <= tedr_pkg::Y_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tedr_pkg::CFG_INV_X:   inv_x_q   <= cfg_data[0];
				tedr_pkg::CFG_INV_Y:   inv_y_q   <= cfg_data[0];
				tedr_pkg::CFG_X_LIMIT: x_limit_q <= cfg_data;
				tedr_pkg::CFG_Y_LIMIT: y_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A position above five cannot occur, but is treated as five so that the
	// incoming byte closes the record.
	assign pos_c = (byte_pos_q > tedr_pkg::POS_W'(tedr_pkg::HELD_LEN))
		? tedr_pkg::POS_W'(tedr_pkg::HELD_LEN) : byte_pos_q;

	assign closing_c = packet_last || (pos_c == tedr_pkg::POS_W'(tedr_pkg::HELD_LEN));

	// Only a closing byte needs room in the output register; plain bytes just
	// land in the holding registers.
	assign in_ready = !closing_c || !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// Assemble the full record: held bytes below the position, the incoming
	// byte at it, zeros beyond (short record at packet end).
	always_comb begin
		for (int i = 0; i < tedr_pkg::REC_LEN; i++) begin
			if (i < tedr_pkg::HELD_LEN && tedr_pkg::POS_W'(i) < pos_c) begin
				rec_c[i] = held_q[i];
			end else if (tedr_pkg::POS_W'(i) == pos_c) begin
				rec_c[i] = packet_byte;
			end else begin
				rec_c[i] = '0;
			end
		end
	end

	// byte 1: low nibble is X[11:8], high nibble is Y[11:8]
	assign raw_x_c = {rec_c[1][3:0], rec_c[2]};
	assign raw_y_c = {rec_c[1][7:4], rec_c[3]};

	always_comb begin
		res_c.slot_id         = rec_c[0][3:0];
		res_c.touching        = rec_c[0][7];
		res_c.pos_x           = '0;
		res_c.pos_y           = '0;
		res_c.touch_major     = '0;
		res_c.pressure        = '0;
		res_c.packet_end      = packet_last;
		res_c.packet_too_long = rec_cnt_q >= tedr_pkg::CNT_W'(tedr_pkg::MAX_RECORDS);
		// a lifted finger reports no position, width or pressure
		if (rec_c[0][7]) begin
			res_c.pos_x       = tedr_pkg::mirror(raw_x_c, x_limit_q, inv_x_q);
			res_c.pos_y       = tedr_pkg::mirror(raw_y_c, y_limit_q, inv_y_q);
			res_c.touch_major = rec_c[4];
			res_c.pressure    = rec_c[5];
		end
	end

	// position and per-packet record count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			rec_cnt_q  <= '0;
		end else if (in_xfer) begin
			if (!closing_c) begin
				byte_pos_q <= pos_c + 1'b1;
			end else begin
				byte_pos_q <= '0;
				if (packet_last) begin
					rec_cnt_q <= '0;
				end else if (rec_cnt_q != tedr_pkg::CNT_MAX) begin
					rec_cnt_q <= rec_cnt_q + 1'b1;
				end
			end
		end
	end

	// held record bytes, payload only
	always_ff @(posedge clk) begin
		if (in_xfer && !closing_c) begin
			held_q[pos_c] <= packet_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && closing_c) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && closing_c) begin
			res_q <= res_c;
		end
	end

	assign out_valid       = out_valid_q;
	assign slot_id         = res_q.slot_id;
	assign touching        = res_q.touching;
	assign pos_x           = res_q.pos_x;
	assign pos_y           = res_q.pos_y;
	assign touch_major     = res_q.touch_major;
	assign pressure        = res_q.pressure;
	assign packet_end      = res_q.packet_end;
	assign packet_too_long = res_q.packet_too_long;

endmodule

FILE: rtl/tedr_checker.sv
// ----------------------------------------------------------------------------
// tedr_checker - port-level checks for the touch event record decoder
// Watches the top level's ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module tedr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [11:0] cfg_data,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  packet_byte,
	input logic        packet_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  slot_id,
	input logic        touching,
	input logic [11:0] pos_x,
	input logic [11:0] pos_y,
	input logic [7:0]  touch_major,
	input logic [7:0]  pressure,
	input logic        packet_end,
	input logic        packet_too_long
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot_id) && $stable(touching)
			&& $stable(pos_x) && $stable(pos_y) && $stable(packet_end))
		else $error("stalled result changed");

	// lifted finger carries no position, width or pressure
	a_lifted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !touching |-> pos_x == 12'd0 && pos_y == 12'd0
			&& touch_major == 8'd0 && pressure == 8'd0)
		else $error("lifted finger with non-zero data");

	// an empty output register never blocks the byte stream
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// the final byte of a packet always yields a packet-end record next cycle
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && packet_last |=> out_valid && packet_end)
		else $error("packet end not emitted");

endmodule

bind touch_event_record_decoder tedr_checker u_tedr_checker (.*);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking testbench for touch_event_record_decoder
// Feeds event packets byte by byte, predicts every decoded finger record,
// and compares each record transfer field by field with the oldest
// prediction. A short hand-written table is followed by random packets
// under several mirror settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 10;
	localparam int QUIET_LIMIT = 2000;  // cycles with no transfer on any channel
	localparam int SETTLE_CYCLES = 4;   // result lands in the cycle after its closing byte
	localparam int PHASE_BYTES = 30;
	localparam int N_PHASES = 6;
	localparam int N_DIR = 23;

	localparam tedr_pkg::result_t NO_REC = '0;

	// clock, reset and DUT ports; every input known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = tedr_pkg::CFG_INV_X;
	logic [11:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  packet_byte = '0;
	logic        packet_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  slot_id;
	logic        touching;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [7:0]  touch_major;
	logic [7:0]  pressure;
	logic        packet_end;
	logic        packet_too_long;

	always #HALF_PERIOD clk = ~clk;

	touch_event_record_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.packet_byte(packet_byte),
		.packet_last(packet_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot_id(slot_id),
		.touching(touching),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.touch_major(touch_major),
		.pressure(pressure),
		.packet_end(packet_end),
		.packet_too_long(packet_too_long)
	);

	// ------------------------------------------------------------------------
	// Record decoder prediction: own copy of mirror settings and record state
	// ------------------------------------------------------------------------
	logic                         mir_x_en = 1'b0;
	logic                         mir_y_en = 1'b0;
	logic [tedr_pkg::COORD_W-1:0] panel_x = tedr_pkg::X_LIMIT_RST;
	logic [tedr_pkg::COORD_W-1:0] panel_y = tedr_pkg::Y_LIMIT_RST;
	logic [2:0]                   bytes_held = '0;
	logic [7:0]                   held_bytes [tedr_pkg::HELD_LEN];
	logic [3:0]                   recs_in_packet = '0;

	tedr_pkg::result_t pending_records [$];  // decoded records still to come out

	int n_errors = 0;
	int n_bytes = 0;
	int n_checked = 0;
	int n_packets = 0;
	int n_short = 0;
	int n_overlong = 0;
	int n_lifted = 0;

	// mirrored coordinate, floored at zero when it would go negative
	function automatic logic [tedr_pkg::COORD_W-1:0] flip_coord(
		input logic [tedr_pkg::COORD_W-1:0] c,
		input logic [tedr_pkg::COORD_W-1:0] edge_lim,
		input logic                         en
	);
		if (!en) begin
			return c;
		end
		if (c > edge_lim) begin
			return '0;
		end
		return edge_lim - c;
	endfunction

	// take one accepted byte; a record comes out on the sixth byte or on
	// the packet's last byte, missing bytes read as zero
	task automatic decode_byte(
		input  logic [7:0]        data,
		input  logic              eop,
		output bit                emitted,
		output tedr_pkg::result_t rec_out
	);
		logic [2:0]                   fill;
		logic [7:0]                   rec [tedr_pkg::REC_LEN];
		logic [tedr_pkg::COORD_W-1:0] cx;
		logic [tedr_pkg::COORD_W-1:0] cy;
		fill = (bytes_held > tedr_pkg::HELD_LEN) ? 3'(tedr_pkg::HELD_LEN) : bytes_held;
		emitted = 1'b0;
		rec_out = NO_REC;
		if (fill < tedr_pkg::HELD_LEN && !eop) begin
			held_bytes[fill] = data;
			bytes_held = fill + 3'd1;
			return;
		end
		for (int i = 0; i < tedr_pkg::REC_LEN; i++) begin
			rec[i] = (i < fill) ? held_bytes[i] : 8'h00;
		end
		rec[fill] = data;
		cx = flip_coord({rec[1][3:0], rec[2]}, panel_x, mir_x_en);
		cy = flip_coord({rec[1][7:4], rec[3]}, panel_y, mir_y_en);
		rec_out.slot_id = rec[0][3:0];
		rec_out.touching = rec[0][7];
		// lifted finger: position, width and pressure all read as zero
		rec_out.pos_x = rec[0][7] ? cx : '0;
		rec_out.pos_y = rec[0][7] ? cy : '0;
		rec_out.touch_major = rec[0][7] ? rec[4] : 8'h00;
		rec_out.pressure = rec[0][7] ? rec[5] : 8'h00;
		rec_out.packet_end = eop;
		rec_out.packet_too_long = (recs_in_packet >= tedr_pkg::MAX_RECORDS);
		emitted = 1'b1;
		if (fill < tedr_pkg::HELD_LEN) n_short++;
		if (rec_out.packet_too_long) n_overlong++;
		if (!rec[0][7]) n_lifted++;
		bytes_held = '0;
		if (eop) begin
			recs_in_packet = '0;
		end else if (recs_in_packet != tedr_pkg::CNT_MAX) begin
			recs_in_packet = recs_in_packet + 4'd1;
		end
	endtask

	// ------------------------------------------------------------------------
	// Directed table: reset settings, extremes, lifted finger, short records.
	// The closing row of a record carries the typed-in result where it is
	// obvious; otherwise the prediction stands.
	// ------------------------------------------------------------------------
	typedef struct {
		logic [7:0]        data;
		logic              eop;
		bit                typed;
		tedr_pkg::result_t want;
	} dir_row_t;

	dir_row_t dir_rows [N_DIR] = '{
		// full record, slot 3 touching, reset settings so no mirroring
		'{8'h83, 1'b0, 1'b0, NO_REC},
		'{8'h21, 1'b0, 1'b0, NO_REC},
		'{8'h34, 1'b0, 1'b0, NO_REC},
		'{8'h56, 1'b0, 1'b0, NO_REC},
		'{8'h78, 1'b0, 1'b0, NO_REC},
		'{8'h9A, 1'b0, 1'b1,
			{4'h3, 1'b1, 12'd308, 12'd598, 8'h78, 8'h9A, 1'b0, 1'b0}},
		// lifted finger, all other bytes high, packet closes on byte 6
		'{8'h05, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b1, 1'b1,
			{4'h5, 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 1'b1, 1'b0}},
		// short record: packet ends on byte 3, Y low byte and the rest zero
		'{8'h8F, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b1, 1'b1,
			{4'hF, 1'b1, 12'd4095, 12'd3840, 8'h00, 8'h00, 1'b1, 1'b0}},
		// one-byte packet
		'{8'h80, 1'b1, 1'b1,
			{4'h0, 1'b1, 12'd0, 12'd0, 8'h00, 8'h00, 1'b1, 1'b0}},
		// all ones, largest coordinates
		'{8'hFF, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 1'b1, 1'b1,
			{4'hF, 1'b1, 12'd4095, 12'd4095, 8'hFF, 8'hFF, 1'b1, 1'b0}},
		// all zeros, one-byte packet
		'{8'h00, 1'b1, 1'b1,
			{4'h0, 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 1'b1, 1'b0}}
	};

	// ------------------------------------------------------------------------
	// Byte sender: bursts of random length, random gaps between them
	// ------------------------------------------------------------------------
	int burst_left = 0;

	// called at a rising edge; returns at the edge of the transfer with
	// in_valid still high, so a following byte can go straight on
	task automatic send_byte(
		input logic [7:0]        data,
		input logic              eop,
		input bit                use_typed,
		input tedr_pkg::result_t typed_rec
	);
		int                gap;
		bit                emitted;
		tedr_pkg::result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		packet_byte <= data;
		packet_last <= eop;
		do @(posedge clk); while (!in_ready);
		n_bytes++;
		if (eop) n_packets++;
		decode_byte(data, eop, emitted, predicted);
		if (emitted) begin
			pending_records.push_back(use_typed ? typed_rec : predicted);
		end
	endtask

	// well-formed packet; the final record is sometimes cut short
	task automatic send_packet(input int n_recs);
		int         rec_len;
		logic [7:0] data;
		for (int r = 0; r < n_recs; r++) begin
			rec_len = tedr_pkg::REC_LEN;
			if (r == n_recs - 1 && $urandom_range(0, 2) == 0) begin
				rec_len = $urandom_range(1, tedr_pkg::REC_LEN - 1);
			end
			for (int k = 0; k < rec_len; k++) begin
				data = 8'($urandom_range(0, 255));
				// mostly fingers down, so the coordinate path gets exercised
				if (k == 0) data[7] = ($urandom_range(0, 3) != 0);
				send_byte(data, (r == n_recs - 1) && (k == rec_len - 1), 1'b0, NO_REC);
			end
		end
	endtask

	// noise: random bytes, packet ends at random places
	task automatic send_noise();
		int len;
		len = $urandom_range(1, 30);
		for (int k = 0; k < len; k++) begin
			send_byte(8'($urandom_range(0, 255)),
				(k == len - 1) || ($urandom_range(0, 9) == 0), 1'b0, NO_REC);
		end
	endtask

	// ------------------------------------------------------------------------
	// Register writes, only once the decoder has gone quiet
	// ------------------------------------------------------------------------
	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tedr_pkg::CFG_INV_X:   mir_x_en = val[0];
			tedr_pkg::CFG_INV_Y:   mir_y_en = val[0];
			tedr_pkg::CFG_X_LIMIT: panel_x = val;
			tedr_pkg::CFG_Y_LIMIT: panel_y = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(
		input logic        inv_x,
		input logic        inv_y,
		input logic [11:0] lim_x,
		input logic [11:0] lim_y
	);
		write_reg(tedr_pkg::CFG_INV_X, {11'd0, inv_x});
		write_reg(tedr_pkg::CFG_INV_Y, {11'd0, inv_y});
		write_reg(tedr_pkg::CFG_X_LIMIT, lim_x);
		write_reg(tedr_pkg::CFG_Y_LIMIT, lim_y);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and wait for every predicted record to come out
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_records.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: ready pattern style chosen by bits 8:7 of a free-running tick count
	// ------------------------------------------------------------------------
	int unsigned rx_tick = 0;
	int          rx_run = 0;
	logic        rx_hold = 1'b0;

	always @(posedge clk) begin
		rx_tick++;
		case (rx_tick[8:7])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom_range(0, 1));
			2'd2: out_ready <= (rx_tick[1:0] == 2'd0);
			default: begin
				// long stretches of stall and of ready
				if (rx_run == 0) begin
					rx_hold = ~rx_hold;
					rx_run = $urandom_range(1, 20);
				end
				rx_run--;
				out_ready <= ~rx_hold;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Record checker
	// ------------------------------------------------------------------------
	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin
		tedr_pkg::result_t want;
		if (out_valid && out_ready) begin
			if (pending_records.size() == 0) begin
				$display("%0t: unexpected record, slot %0d touching %0d x %0d y %0d",
					$time, slot_id, touching, pos_x, pos_y);
				n_errors++;
			end else begin
				want = pending_records.pop_front();
				n_checked++;
				check_field("slot_id", 32'(want.slot_id), 32'(slot_id));
				check_field("touching", 32'(want.touching), 32'(touching));
				check_field("pos_x", 32'(want.pos_x), 32'(pos_x));
				check_field("pos_y", 32'(want.pos_y), 32'(pos_y));
				check_field("touch_major", 32'(want.touch_major), 32'(touch_major));
				check_field("pressure", 32'(want.pressure), 32'(pressure));
				check_field("packet_end", 32'(want.packet_end), 32'(packet_end));
				check_field("packet_too_long", 32'(want.packet_too_long),
					32'(packet_too_long));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too long without a transfer on any channel
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d records outstanding",
				$time, quiet_cycles, pending_records.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int phase_start;
		int pick;
		for (int i = 0; i < tedr_pkg::HELD_LEN; i++) held_bytes[i] = 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under reset settings
		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].data, dir_rows[i].eop, dir_rows[i].typed, dir_rows[i].want);
		end

		// random phases, each under its own mirror settings
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			case (ph)
				0: apply_settings(1'b1, 1'b1, 12'd0, 12'd0);        // everything underflows
				1: apply_settings(1'b1, 1'b1, 12'd4095, 12'd4095);
				2: apply_settings(1'b1, 1'b0, 12'd720, 12'($urandom_range(0, 4095)));
				3: apply_settings(1'b0, 1'b1, 12'($urandom_range(0, 4095)), 12'd1280);
				4: apply_settings(1'b1, 1'b1, 12'($urandom_range(0, 4095)),
					12'($urandom_range(0, 4095)));
				default: apply_settings(1'b0, 1'b0, tedr_pkg::X_LIMIT_RST,
					tedr_pkg::Y_LIMIT_RST);
			endcase
			phase_start = n_bytes;
			// overlong packet first in the opening phase, past counter saturation
			if (ph == 0) send_packet(17);
			while (n_bytes - phase_start < PHASE_BYTES) begin
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					send_noise();
				end else if (pick < 7) begin
					send_packet($urandom_range(1, 3));
				end else if (pick < 9) begin
					send_packet($urandom_range(8, 12));
				end else begin
					send_packet($urandom_range(13, 17));
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d bytes in %0d packets, %0d records checked over %0d settings.",
			n_bytes, n_packets, n_checked, N_PHASES + 1);
		$display("Of those: %0d short, %0d beyond the record limit, %0d lifted fingers.",
			n_short, n_overlong, n_lifted);
		if (n_errors == 0 && pending_records.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/tedr_pkg.sv
rtl/touch_event_record_decoder.sv
rtl/tedr_checker.sv
tb/tb_top.sv
